### sv/ucfp_pkg.sv
// Types, codes and character constants shared by the serial command frame parser.
// No dependencies.
`default_nettype none
package ucfp_pkg;

  localparam int CNT_W         = 7;   // holds a line position up to 127
  localparam int CODE_CHARS    = 4;
  localparam int SCALE_DIGITS  = 8;
  localparam int LENGTH_DIGITS = 4;
  localparam int INDEX_DIGITS  = 5;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_C    = 8'h63;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [1:0] REG_LOG   = 2'd0;
  localparam logic [1:0] REG_WAVE  = 2'd1;
  localparam logic [1:0] REG_AMEND = 2'd2;

  localparam logic [1:0] TYPE_F32  = 2'd0;
  localparam logic [1:0] TYPE_U32  = 2'd1;
  localparam logic [1:0] TYPE_S32  = 2'd2;
  localparam logic [1:0] TYPE_CHAR = 2'd3;

  typedef enum logic [3:0] {
    PH_READY, PH_LOG, PH_WBUF, PH_WTYPE, PH_WMODE, PH_NAME, PH_SCALE,
    PH_LENGTH, PH_DATA, PH_ABUF, PH_AINDEX, PH_AVALUE
  } phase_e;

  typedef enum logic [2:0] {
    EV_TEXT, EV_LINE_END, EV_ERROR, EV_HEADER, EV_WRITE, EV_DONE
  } kind_e;

  typedef enum logic [1:0] {
    JOB_STORE, JOB_LINE, JOB_EVENT
  } job_op_e;

  typedef enum logic [1:0] {
    B_IDLE, B_LINE, B_END, B_DONE
  } back_state_e;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  byte_value;
    logic        buffer_sel;
    logic [1:0]  data_type;
    logic        draw_mode;
    logic [26:0] scale;
    logic [16:0] count_or_index;
    logic [31:0] value_bits;
  } event_t;

  typedef struct packed {
    job_op_e          op;
    logic [7:0]       ch;
    logic [CNT_W-1:0] cnt;       // store position or line length
    logic             add_done;  // a transfer-done event follows the event
    event_t           ev;
  } job_t;

  typedef struct packed {
    logic [31:0] log_code;
    logic [31:0] wave_code;
    logic [31:0] amend_code;
  } codes_t;

  function automatic logic [7:0] code_byte(input logic [31:0] code, input logic [1:0] p);
    logic [7:0] b;
    case (p)
      2'd0:    b = code[31:24];
      2'd1:    b = code[23:16];
      2'd2:    b = code[15:8];
      default: b = code[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### sv/ucfp_if.sv
// Channel interfaces of the command frame parser: received bytes, events, register writes.
// No dependencies: the register index width is sized with a literal, not from ucfp_pkg.
`default_nettype none
interface ucfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  byte_value;
  logic        buffer_sel;
  logic [1:0]  data_type;
  logic        draw_mode;
  logic [26:0] scale;
  logic [16:0] count_or_index;
  logic [31:0] value_bits;
  logic        last;
  modport source (output valid, output event_kind, output byte_value, output buffer_sel,
                  output data_type, output draw_mode, output scale, output count_or_index,
                  output value_bits, output last, input ready);
  modport sink   (input valid, input event_kind, input byte_value, input buffer_sel,
                  input data_type, input draw_mode, input scale, input count_or_index,
                  input value_bits, input last, output ready);
endinterface

interface ucfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

### sv/ucfp_fifo.sv
// Two-entry job queue between the parser front end and the event back end.
// Depends on ucfp_pkg (job_t).
`default_nettype none
module ucfp_fifo
  import ucfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  job_t      push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_data_o
);
  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

### sv/ucfp_front.sv
// Front end: classifies each received byte against the parser phase and issues at most one job.
// Depends on ucfp_pkg.
`default_nettype none
module ucfp_front
  import ucfp_pkg::*;
#(
  parameter int LINE_CHARS = 34,
  parameter int NAME_CHARS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  output logic            byte_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  codes_t          codes_i,
  output logic            job_valid_o,
  output job_t            job_o,
  input  wire logic       job_ready_i
);
  localparam int PW = ($clog2(LINE_CHARS + 1) > 4) ? $clog2(LINE_CHARS + 1) : 4;
  localparam int NAME_LIM = (NAME_CHARS < LINE_CHARS) ? NAME_CHARS : LINE_CHARS;

  phase_e        phase_q, phase_d, phase_nx;
  logic [PW-1:0] pos_q, pos_d;
  logic [23:0]   code_q, code_d;
  logic [26:0]   scale_q, scale_d;
  logic [13:0]   len_q, len_d;
  logic [13:0]   vals_q, vals_d;
  logic          buf_q, buf_d;
  logic [1:0]    typ_q, typ_d;
  logic          mode_q, mode_d;
  logic [31:0]   word_q, word_d;

  logic          accept, fail, clr;
  logic [7:0]    c, digit;
  logic          is_digit;
  logic [1:0]    pos2;
  logic [31:0]   word_n, full_code;
  logic [13:0]   vals_n;

  assign byte_ready_o = job_ready_i;
  assign accept = byte_valid_i && job_ready_i;
  assign c = rx_byte_i;
  assign digit = c - CH_0;
  assign is_digit = c inside {[CH_0:CH_9]};
  assign pos2 = pos_q[1:0];

  always_comb begin
    phase_d = accept ? phase_nx : phase_q;
  end

  always_comb begin
    phase_nx    = phase_q;
    pos_d       = pos_q;
    code_d      = code_q;
    scale_d     = scale_q;
    len_d       = len_q;
    vals_d      = vals_q;
    buf_d       = buf_q;
    typ_d       = typ_q;
    mode_d      = mode_q;
    word_d      = word_q;
    fail        = 1'b0;
    clr         = 1'b0;
    job_valid_o = 1'b0;
    job_o       = '0;
    word_n      = word_q | (32'(c) << {pos2, 3'b000});
    vals_n      = vals_q;
    full_code   = {code_q, c};
    if (accept && !(phase_q != PH_DATA && phase_q != PH_AVALUE && c == 8'h00)) begin
      if (phase_q != PH_DATA && c == CH_STAR) begin
        fail = 1'b1;
      end else begin
        case (phase_q)
          PH_LOG, PH_NAME: begin
            if (c == CH_NL) begin
              job_valid_o = 1'b1;
              job_o.op    = JOB_LINE;
              job_o.cnt   = CNT_W'(pos_q);
              if (phase_q == PH_LOG) begin
                clr      = 1'b1;
                phase_nx = PH_READY;
              end else begin
                pos_d    = '0;
                phase_nx = PH_SCALE;
              end
            end else if ((phase_q == PH_LOG && pos_q < PW'(LINE_CHARS)) ||
                         (phase_q == PH_NAME && pos_q < PW'(NAME_LIM))) begin
              job_valid_o = 1'b1;
              job_o.op    = JOB_STORE;
              job_o.ch    = c;
              job_o.cnt   = CNT_W'(pos_q);
              pos_d       = pos_q + 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          PH_WBUF, PH_ABUF: begin
            if (c == CH_A || c == CH_B) begin
              buf_d    = (c == CH_B);
              phase_nx = (phase_q == PH_WBUF) ? PH_WTYPE : PH_AINDEX;
            end else begin
              fail = 1'b1;
            end
          end
          PH_WTYPE: begin
            phase_nx = PH_WMODE;
            if (c == CH_F) typ_d = TYPE_F32;
            else if (c == CH_U) typ_d = TYPE_U32;
            else if (c == CH_S) typ_d = TYPE_S32;
            else if (c == CH_C) typ_d = TYPE_CHAR;
            else fail = 1'b1;
          end
          PH_WMODE: begin
            if (c == CH_D || c == CH_L) begin
              mode_d   = (c == CH_L);
              phase_nx = PH_NAME;
            end else begin
              fail = 1'b1;
            end
          end
          PH_SCALE, PH_AINDEX: begin
            if (c == CH_NL) begin
              pos_d    = '0;
              word_d   = '0;
              phase_nx = (phase_q == PH_SCALE) ? PH_LENGTH : PH_AVALUE;
            end else if (!is_digit || pos_q >= PW'((phase_q == PH_SCALE) ? SCALE_DIGITS
                                                                         : INDEX_DIGITS)) begin
              fail = 1'b1;
            end else begin
              scale_d = (scale_q << 3) + (scale_q << 1) + 27'(digit);
              pos_d   = pos_q + 1'b1;
            end
          end
          PH_LENGTH: begin
            if (c == CH_NL) begin
              pos_d       = '0;
              word_d      = '0;
              phase_nx    = PH_DATA;
              job_valid_o = 1'b1;
              job_o.op    = JOB_EVENT;
              job_o.ev.event_kind     = EV_HEADER;
              job_o.ev.buffer_sel     = buf_q;
              job_o.ev.data_type      = typ_q;
              job_o.ev.draw_mode      = mode_q;
              job_o.ev.scale          = scale_q;
              job_o.ev.count_or_index = 17'(len_q);
            end else if (!is_digit || pos_q >= PW'(LENGTH_DIGITS)) begin
              fail = 1'b1;
            end else begin
              len_d = (len_q << 3) + (len_q << 1) + 14'(digit);
              pos_d = pos_q + 1'b1;
            end
          end
          PH_DATA: begin
            job_o.ev.event_kind     = EV_WRITE;
            job_o.ev.buffer_sel     = buf_q;
            job_o.ev.data_type      = typ_q;
            job_o.ev.draw_mode      = mode_q;
            job_o.ev.count_or_index = 17'(vals_q);
            job_o.op                = JOB_EVENT;
            if (typ_q == TYPE_CHAR) begin
              job_valid_o         = 1'b1;
              job_o.ev.value_bits = {24'h000000, c};
              vals_n              = vals_q + 14'd1;
            end else if (pos2 == 2'd3) begin
              job_valid_o         = 1'b1;
              job_o.ev.value_bits = word_n;
              vals_n              = vals_q + 14'd1;
              pos_d               = '0;
              word_d              = '0;
            end else begin
              word_d = word_n;
              pos_d  = PW'(pos2) + 1'b1;
            end
            vals_d = vals_n;
            if (vals_n >= len_q) begin
              clr      = 1'b1;
              phase_nx = PH_READY;
              if (job_valid_o) begin
                job_o.add_done = 1'b1;
              end else begin
                // no write this byte: a lone done event
                job_valid_o = 1'b1;
                job_o.ev    = '0;
                job_o.ev.event_kind = EV_DONE;
              end
            end
          end
          PH_AVALUE: begin
            if (pos2 == 2'd3) begin
              job_valid_o             = 1'b1;
              job_o.op                = JOB_EVENT;
              job_o.ev.event_kind     = EV_WRITE;
              job_o.ev.buffer_sel     = buf_q;
              job_o.ev.data_type      = typ_q;
              job_o.ev.draw_mode      = mode_q;
              job_o.ev.count_or_index = scale_q[16:0];
              job_o.ev.value_bits     = word_n;
              clr                     = 1'b1;
              phase_nx                = PH_READY;
            end else begin
              word_d = word_n;
              pos_d  = PW'(pos2) + 1'b1;
            end
          end
          default: begin
            // ready phase: match one code character per byte
            phase_nx = PH_READY;
            if (pos_q >= PW'(CODE_CHARS)) begin
              fail = 1'b1;
            end else if (c != code_byte(codes_i.log_code, pos2) &&
                         c != code_byte(codes_i.wave_code, pos2) &&
                         c != code_byte(codes_i.amend_code, pos2)) begin
              fail = 1'b1;
            end else if (pos2 != 2'd3) begin
              code_d = {code_q[15:0], c};
              pos_d  = pos_q + 1'b1;
            end else if (full_code == codes_i.log_code) begin
              clr      = 1'b1;
              phase_nx = PH_LOG;
            end else if (full_code == codes_i.wave_code) begin
              clr      = 1'b1;
              phase_nx = PH_WBUF;
            end else if (full_code == codes_i.amend_code) begin
              clr      = 1'b1;
              phase_nx = PH_ABUF;
            end else begin
              fail = 1'b1;
            end
          end
        endcase
      end
    end
    if (fail) begin
      clr         = 1'b1;
      phase_nx    = PH_READY;
      job_valid_o = 1'b1;
      job_o       = '0;
      job_o.op    = JOB_EVENT;
      job_o.ev.event_kind = EV_ERROR;
      job_o.ev.byte_value = c;
    end
    if (clr) begin
      pos_d   = '0;
      scale_d = '0;
      len_d   = '0;
      vals_d  = '0;
      word_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_READY;
      pos_q   <= '0;
      code_q  <= '0;
      scale_q <= '0;
      len_q   <= '0;
      vals_q  <= '0;
      buf_q   <= 1'b0;
      typ_q   <= '0;
      mode_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      code_q  <= code_d;
      scale_q <= scale_d;
      len_q   <= len_d;
      vals_q  <= vals_d;
      buf_q   <= buf_d;
      typ_q   <= typ_d;
      mode_q  <= mode_d;
      word_q  <= word_d;
    end
  end
endmodule
`default_nettype wire

### sv/ucfp_back.sv
// Back end: owns the line store, runs jobs from the queue and drives the event output register.
// Depends on ucfp_pkg.
`default_nettype none
module ucfp_back
  import ucfp_pkg::*;
#(
  parameter int LINE_CHARS = 34
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      evt_valid_o,
  output event_t    evt_o,
  output logic      evt_last_o,
  input  wire logic evt_ready_i
);
  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int CW = $clog2(LINE_CHARS + 1);

  back_state_e   state_q, state_d;
  logic [CW-1:0] idx_q, idx_d, n_q, n_d;
  logic [7:0]    line_mem [LINE_CHARS];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          out_valid_q, out_valid_d, last_q, last_d, load;
  event_t        out_q, out_d;
  logic          slot_free;

  assign slot_free   = !out_valid_q || evt_ready_i;
  assign evt_valid_o = out_valid_q;
  assign evt_o       = out_q;
  assign evt_last_o  = last_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          if (job_i.op == JOB_LINE) begin
            state_d = (job_i.cnt == '0) ? B_END : B_LINE;
          end else if (job_i.op == JOB_EVENT && slot_free && job_i.add_done) begin
            state_d = B_DONE;
          end
        end
      end
      B_LINE: if (slot_free && (idx_q + 1'b1) == n_q) state_d = B_END;
      B_END, B_DONE: if (slot_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    job_pop_o = 1'b0;
    wr_en     = 1'b0;
    load      = 1'b0;
    out_d     = out_q;
    last_d    = last_q;
    idx_d     = idx_q;
    n_d       = n_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            JOB_STORE: begin
              job_pop_o = 1'b1;
              wr_en     = 1'b1;
            end
            JOB_LINE: begin
              job_pop_o = 1'b1;
              idx_d     = '0;
              n_d       = CW'(job_i.cnt);
            end
            JOB_EVENT: begin
              if (slot_free) begin
                job_pop_o = 1'b1;
                load      = 1'b1;
                out_d     = job_i.ev;
                last_d    = !job_i.add_done;
              end
            end
            default: job_pop_o = 1'b1;
          endcase
        end
      end
      B_LINE: begin
        if (slot_free) begin
          load             = 1'b1;
          out_d            = '0;
          out_d.event_kind = EV_TEXT;
          out_d.byte_value = rd_q;
          last_d           = 1'b0;
          idx_d            = idx_q + 1'b1;
        end
      end
      B_END: begin
        if (slot_free) begin
          load             = 1'b1;
          out_d            = '0;
          out_d.event_kind = EV_LINE_END;
          last_d           = 1'b1;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          load             = 1'b1;
          out_d            = '0;
          out_d.event_kind = EV_DONE;
          last_d           = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_d = load ? 1'b1 : (evt_ready_i ? 1'b0 : out_valid_q);
  end

  // read port prefetches the next character so a line streams one per cycle while the output is not stalled
  assign rd_addr = (idx_d < CW'(LINE_CHARS)) ? idx_d[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[job_i.cnt[AW-1:0]] <= job_i.ch;
    end
    rd_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
  end
endmodule
`default_nettype wire

### sv/uart_command_frame_parser.sv
// Serial command frame parser: one received byte per transfer in, a stream of events out.
// The front end takes a byte whenever its two-entry job queue has room and issues at most
// one job. The back end runs each job as it comes off the queue; a write that ends a
// transfer is followed by a done event, and a text line streams from the line store's
// single read port at one character per cycle while the event output is not stalled,
// then a line end event. Registers hold the three command codes and are written through
// the cfg channel, always ready.
// Depends on ucfp_pkg, ucfp_if, ucfp_fifo, ucfp_front, ucfp_back.
`default_nettype none
module uart_command_frame_parser
  import ucfp_pkg::*;
#(
  parameter int LINE_CHARS = 34,
  parameter int NAME_CHARS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ucfp_rx_if.sink     rx,
  ucfp_cfg_if.sink    cfg,
  ucfp_evt_if.source  evt
);
  codes_t codes_q;
  logic   f_valid, f_ready, b_valid, b_pop, last;
  job_t   f_job, b_job;
  event_t ev;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_LOG:   codes_q.log_code   <= cfg.wdata;
        REG_WAVE:  codes_q.wave_code  <= cfg.wdata;
        REG_AMEND: codes_q.amend_code <= cfg.wdata;
        default: ;
      endcase
    end
  end

  ucfp_front #(.LINE_CHARS(LINE_CHARS), .NAME_CHARS(NAME_CHARS)) u_front (
    .clk_i, .rst_ni,
    .byte_valid_i (rx.valid),
    .byte_ready_o (rx.ready),
    .rx_byte_i    (rx.rx_byte),
    .codes_i      (codes_q),
    .job_valid_o  (f_valid),
    .job_o        (f_job),
    .job_ready_i  (f_ready)
  );

  ucfp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_pop),
    .pop_data_o   (b_job)
  );

  ucfp_back #(.LINE_CHARS(LINE_CHARS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (b_valid),
    .job_i       (b_job),
    .job_pop_o   (b_pop),
    .evt_valid_o (evt.valid),
    .evt_o       (ev),
    .evt_last_o  (last),
    .evt_ready_i (evt.ready)
  );

  assign evt.event_kind     = ev.event_kind;
  assign evt.byte_value     = ev.byte_value;
  assign evt.buffer_sel     = ev.buffer_sel;
  assign evt.data_type      = ev.data_type;
  assign evt.draw_mode      = ev.draw_mode;
  assign evt.scale          = ev.scale;
  assign evt.count_or_index = ev.count_or_index;
  assign evt.value_bits     = ev.value_bits;
  assign evt.last           = last;
endmodule
`default_nettype wire

### sv/ucfp_checker.sv
// Port-level checks on the event channel of the command frame parser, bound to the top level.
// Depends on ucfp_pkg.
`default_nettype none
module ucfp_checker
  import ucfp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        evt_valid,
  input wire logic        evt_ready,
  input wire logic [2:0]  evt_kind,
  input wire logic [7:0]  evt_byte,
  input wire logic        evt_sel,
  input wire logic [26:0] evt_scale,
  input wire logic        evt_last
);
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("event valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ready |=> $stable(evt_kind) && $stable(evt_byte) && $stable(evt_last))
    else $error("event payload changed while stalled");

  // errors, line ends, headers and done events always close a byte's burst
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && (evt_kind == EV_ERROR || evt_kind == EV_LINE_END ||
                  evt_kind == EV_HEADER || evt_kind == EV_DONE) |-> evt_last)
    else $error("terminal event without last");

  a_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && evt_kind == EV_TEXT |-> !evt_last && !evt_sel && evt_scale == '0)
    else $error("text character event malformed");
endmodule

bind uart_command_frame_parser ucfp_checker u_ucfp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_kind  (evt.event_kind),
  .evt_byte  (evt.byte_value),
  .evt_sel   (evt.buffer_sel),
  .evt_scale (evt.scale),
  .evt_last  (evt.last)
);
`default_nettype wire
